### hdl/vq_codebook_video_block_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the decoder modules.
// Each macro states a clocked implication that is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VQ_CODEBOOK_VIDEO_BLOCK_DECODER_UNIT_ASSERT_SVH
`define VQ_CODEBOOK_VIDEO_BLOCK_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define VQD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vqd assertion failed");

// Next-cycle implication.
`define VQD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vqd assertion failed");

`endif

### hdl/vqd_pkg.sv
// ----------------------------------------------------------------------------
// vqd_pkg
// Types and constants shared by the vector-quantization decoder modules.
// ----------------------------------------------------------------------------
package vqd_pkg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [23:0] payload_size;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_V1    = 2'd1,
        OP_V4    = 2'd2,
        OP_ERR   = 2'd3
    } t_op;

    // One command from the parser to the pixel engine.
    typedef struct packed {
        t_op         op;
        logic        tsel;
        logic [7:0]  idx;
        logic [1:0]  quad;
        logic [9:0]  col;
        logic [12:0] row;
        logic [47:0] data;
    } t_cmd;

    localparam logic [1:0]  KIND_FRAME = 2'd0;
    localparam logic [1:0]  KIND_STRIP = 2'd1;
    localparam logic [1:0]  KIND_CHUNK = 2'd2;
    localparam logic [1:0]  KIND_BYTE  = 2'd3;

    localparam logic [15:0] CB_ID_LO = 16'h0020;
    localparam logic [15:0] CB_ID_HI = 16'h0027;
    localparam logic [15:0] VQ_ID_LO = 16'h0030;
    localparam logic [15:0] VQ_ID_HI = 16'h0032;

    localparam int CH_BIT_SEL  = 0;
    localparam int CH_BIT_V1   = 1;
    localparam int CH_BIT_GREY = 2;

    localparam logic [8:0]  TABLE_ENTRIES    = 9'd256;
    localparam logic [10:0] MAX_WIDTH_BLOCKS = 11'd1024;
    localparam logic [12:0] MAX_HEIGHT       = 13'd4096;
    localparam logic [10:0] WIDTH_RESET      = 11'd80;
    localparam logic [7:0]  UV_BIAS          = 8'd128;
    localparam logic [5:0]  FLAG_BITS        = 6'd32;
    localparam logic [2:0]  FLAG_WORD_BYTES  = 3'd4;
    localparam logic [2:0]  GREY_ENTRY_BYTES = 3'd4;
    localparam logic [2:0]  RGB_ENTRY_BYTES  = 3'd6;
    localparam logic [2:0]  V4_BYTES         = 3'd4;
    localparam logic [2:0]  V1_BYTES         = 3'd1;

    function automatic logic [7:0] clip8(input logic signed [10:0] v);
        if (v < 11'sd0) begin
            return 8'd0;
        end else if (v > 11'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage

### hdl/vqd_front.sv
// ----------------------------------------------------------------------------
// vqd_front
// Stream parser: tracks strips and chunks, assembles flag words and codebook
// entries, walks the block grid and issues commands to the pixel engine.
// ----------------------------------------------------------------------------
`include "vq_codebook_video_block_decoder_unit_assert.svh"

module vqd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  vqd_pkg::t_in  i_data,
    output logic          o_stall,
    input  logic          i_cfg_valid,
    input  logic [10:0]   i_cfg_data,
    output logic          o_push,
    output vqd_pkg::t_cmd o_cmd,
    input  logic          i_full
);

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_SKIP     = 8'b0000_0010,
        PH_CB_FLAG  = 8'b0000_0100,
        PH_CB_ENTRY = 8'b0000_1000,
        PH_VQ_FLAG1 = 8'b0001_0000,
        PH_VQ_FLAG2 = 8'b0010_0000,
        PH_VQ_V1    = 8'b0100_0000,
        PH_VQ_V4    = 8'b1000_0000
    } t_phase;

    typedef enum logic [5:0] {
        ADV_NONE   = 6'b00_0001,
        ADV_CB     = 6'b00_0010,
        ADV_CB_RDY = 6'b00_0100,
        ADV_VQ_BLK = 6'b00_1000,
        ADV_VQ_COD = 6'b01_0000,
        ADV_VQ_TYP = 6'b10_0000
    } t_adv;

    function automatic logic flag_at(input logic [31:0] f, input logic [5:0] mp);
        logic [4:0] ix;
        ix = 5'(mp - 6'd1);
        return (mp != 6'd0 && mp <= vqd_pkg::FLAG_BITS) ? f[ix] : 1'b0;
    endfunction

    logic [10:0] r_width;
    logic [12:0] r_strip_top, n_strip_top;
    logic [12:0] r_strip_bot, n_strip_bot;
    logic [9:0]  r_col, n_col;
    logic [12:0] r_row, n_row;
    logic [31:0] r_flags, n_flags;
    logic [5:0]  r_mask, n_mask;
    logic [23:0] r_bytes, n_bytes;
    logic [7:0]  r_chunk, n_chunk;
    logic [8:0]  r_entry, n_entry;
    logic [47:0] r_ebytes, n_ebytes;
    logic [2:0]  r_unit, n_unit;
    t_phase      r_phase, n_phase;
    t_adv        r_adv, n_adv;
    logic        r_halted, n_halted;

    logic        accept;
    logic [10:0] eff_width;
    logic [10:0] col_inc;
    logic [9:0]  nb_col;
    logic [12:0] nb_row;
    logic [2:0]  esize;
    logic [16:0] strip_sum;
    logic [7:0]  in_byte;
    logic [23:0] bytes_dec;
    logic [47:0] ebytes_sh;
    logic [2:0]  unit_inc;
    logic        do_skip;
    logic        do_need;
    logic [2:0]  need_n;
    t_phase      need_ph;
    logic        fin;
    logic [5:0]  mp;
    logic [47:0] entry_fmt;

    assign o_stall   = (r_adv != ADV_NONE) || i_full;
    assign accept    = i_valid && !o_stall;
    assign eff_width = (r_width > vqd_pkg::MAX_WIDTH_BLOCKS) ? vqd_pkg::MAX_WIDTH_BLOCKS
                                                              : r_width;
    assign col_inc   = {1'b0, r_col} + 11'd1;
    assign nb_col    = (col_inc >= eff_width) ? 10'd0 : col_inc[9:0];
    assign nb_row    = (col_inc >= eff_width) ? r_row + 13'd4 : r_row;
    assign esize     = r_chunk[vqd_pkg::CH_BIT_GREY] ? vqd_pkg::GREY_ENTRY_BYTES
                                                     : vqd_pkg::RGB_ENTRY_BYTES;
    assign strip_sum = {4'b0, r_strip_bot} + {1'b0, i_data.value};
    assign in_byte   = i_data.value[7:0];
    assign bytes_dec = r_bytes - 24'd1;
    assign ebytes_sh = {r_ebytes[39:0], in_byte};
    assign unit_inc  = r_unit + 3'd1;

    // Table entry layout: four luma bytes, then u and v with the bias added.
    always_comb begin
        if (r_chunk[vqd_pkg::CH_BIT_GREY]) begin
            entry_fmt = {ebytes_sh[31:0], vqd_pkg::UV_BIAS, vqd_pkg::UV_BIAS};
        end else begin
            entry_fmt = {ebytes_sh[47:16], ebytes_sh[15:8] + vqd_pkg::UV_BIAS,
                         ebytes_sh[7:0] + vqd_pkg::UV_BIAS};
        end
    end

    always_comb begin
        n_strip_top = r_strip_top;
        n_strip_bot = r_strip_bot;
        n_col       = r_col;
        n_row       = r_row;
        n_flags     = r_flags;
        n_mask      = r_mask;
        n_bytes     = r_bytes;
        n_chunk     = r_chunk;
        n_entry     = r_entry;
        n_ebytes    = r_ebytes;
        n_unit      = r_unit;
        n_phase     = r_phase;
        n_adv       = r_adv;
        n_halted    = r_halted;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.op    = vqd_pkg::OP_ERR;
        do_skip     = 1'b0;
        do_need     = 1'b0;
        need_n      = vqd_pkg::V1_BYTES;
        need_ph     = PH_IDLE;
        fin         = 1'b0;
        mp          = r_mask;

        if (r_adv == ADV_CB || r_adv == ADV_CB_RDY) begin
            // One step of the codebook entry search.
            n_adv = ADV_NONE;
            if (r_adv == ADV_CB) begin
                if (r_entry >= vqd_pkg::TABLE_ENTRIES) begin
                    do_skip = 1'b1;
                    fin     = 1'b1;
                end else if (r_chunk[vqd_pkg::CH_BIT_SEL]) begin
                    if (r_mask <= 6'd1) begin
                        do_need = 1'b1;
                        need_n  = vqd_pkg::FLAG_WORD_BYTES;
                        need_ph = PH_CB_FLAG;
                        fin     = 1'b1;
                    end else begin
                        mp = r_mask - 6'd1;
                    end
                end
            end
            if (!fin) begin
                if (!r_chunk[vqd_pkg::CH_BIT_SEL] || flag_at(r_flags, mp)) begin
                    do_need = 1'b1;
                    need_n  = esize;
                    need_ph = PH_CB_ENTRY;
                end else begin
                    n_entry = r_entry + 9'd1;
                    n_adv   = ADV_CB;
                end
            end
            n_mask = mp;
        end else if (r_adv != ADV_NONE) begin
            // One step of the block walk: one block decided per cycle, unless a flag word must be read first.
            n_adv = ADV_NONE;
            if (r_adv == ADV_VQ_BLK) begin
                if (eff_width == 11'd0 || r_row >= r_strip_bot) begin
                    do_skip = 1'b1;
                    fin     = 1'b1;
                end else if (r_chunk[vqd_pkg::CH_BIT_SEL]) begin
                    if (r_mask <= 6'd1) begin
                        do_need = 1'b1;
                        need_n  = vqd_pkg::FLAG_WORD_BYTES;
                        need_ph = PH_VQ_FLAG1;
                        fin     = 1'b1;
                    end else begin
                        mp = r_mask - 6'd1;
                    end
                end
            end
            if (!fin && r_adv != ADV_VQ_TYP) begin
                if (r_chunk[vqd_pkg::CH_BIT_SEL] && !flag_at(r_flags, mp)) begin
                    n_col = nb_col;
                    n_row = nb_row;
                    n_adv = ADV_VQ_BLK;
                    fin   = 1'b1;
                end else if (!r_chunk[vqd_pkg::CH_BIT_V1]) begin
                    if (mp <= 6'd1) begin
                        do_need = 1'b1;
                        need_n  = vqd_pkg::FLAG_WORD_BYTES;
                        need_ph = PH_VQ_FLAG2;
                        fin     = 1'b1;
                    end else begin
                        mp = mp - 6'd1;
                    end
                end
            end
            if (!fin) begin
                do_need = 1'b1;
                if (r_chunk[vqd_pkg::CH_BIT_V1] || !flag_at(r_flags, mp)) begin
                    need_n  = vqd_pkg::V1_BYTES;
                    need_ph = PH_VQ_V1;
                end else begin
                    need_n  = vqd_pkg::V4_BYTES;
                    need_ph = PH_VQ_V4;
                end
            end
            n_mask = mp;
        end else if (accept) begin
            if (i_data.kind == vqd_pkg::KIND_FRAME) begin
                n_strip_top = '0;
                n_strip_bot = '0;
                n_halted    = 1'b0;
                n_phase     = PH_IDLE;
                n_bytes     = '0;
            end else if (!r_halted) begin
                case (i_data.kind)
                    vqd_pkg::KIND_STRIP: begin
                        n_strip_top = r_strip_bot;
                        n_strip_bot = (strip_sum > {4'b0, vqd_pkg::MAX_HEIGHT})
                                    ? vqd_pkg::MAX_HEIGHT : strip_sum[12:0];
                        n_phase     = PH_IDLE;
                        n_bytes     = '0;
                    end
                    vqd_pkg::KIND_CHUNK: begin
                        n_chunk  = i_data.value[7:0];
                        n_bytes  = i_data.payload_size;
                        n_flags  = '0;
                        n_mask   = '0;
                        n_entry  = '0;
                        n_ebytes = '0;
                        n_unit   = '0;
                        if (i_data.value >= vqd_pkg::CB_ID_LO &&
                            i_data.value <= vqd_pkg::CB_ID_HI) begin
                            n_adv = ADV_CB;
                        end else if (i_data.value >= vqd_pkg::VQ_ID_LO &&
                                     i_data.value <= vqd_pkg::VQ_ID_HI) begin
                            n_col = '0;
                            n_row = r_strip_top;
                            n_adv = ADV_VQ_BLK;
                        end else begin
                            n_halted = 1'b1;
                            n_phase  = PH_IDLE;
                            n_bytes  = '0;
                            o_push   = 1'b1;
                        end
                    end
                    vqd_pkg::KIND_BYTE: begin
                        if (r_phase != PH_IDLE && r_bytes != 24'd0) begin
                            n_bytes = bytes_dec;
                            case (r_phase)
                                PH_CB_FLAG, PH_VQ_FLAG1, PH_VQ_FLAG2: begin
                                    n_flags = {r_flags[23:0], in_byte};
                                    n_unit  = unit_inc;
                                    if (unit_inc == vqd_pkg::FLAG_WORD_BYTES) begin
                                        n_mask = vqd_pkg::FLAG_BITS;
                                        if (r_phase == PH_CB_FLAG) begin
                                            n_adv = ADV_CB_RDY;
                                        end else if (r_phase == PH_VQ_FLAG1) begin
                                            n_adv = ADV_VQ_COD;
                                        end else begin
                                            n_adv = ADV_VQ_TYP;
                                        end
                                    end
                                end
                                PH_CB_ENTRY: begin
                                    n_ebytes = ebytes_sh;
                                    n_unit   = unit_inc;
                                    if (unit_inc == esize) begin
                                        o_push     = 1'b1;
                                        o_cmd.op   = vqd_pkg::OP_WRITE;
                                        o_cmd.tsel = r_chunk[vqd_pkg::CH_BIT_V1];
                                        o_cmd.idx  = r_entry[7:0];
                                        o_cmd.data = entry_fmt;
                                        n_entry    = r_entry + 9'd1;
                                        n_adv      = ADV_CB;
                                    end
                                end
                                PH_VQ_V1: begin
                                    o_push    = 1'b1;
                                    o_cmd.op  = vqd_pkg::OP_V1;
                                    o_cmd.idx = in_byte;
                                    o_cmd.col = r_col;
                                    o_cmd.row = r_row;
                                    n_col     = nb_col;
                                    n_row     = nb_row;
                                    n_adv     = ADV_VQ_BLK;
                                end
                                PH_VQ_V4: begin
                                    o_push     = 1'b1;
                                    o_cmd.op   = vqd_pkg::OP_V4;
                                    o_cmd.idx  = in_byte;
                                    o_cmd.quad = r_unit[1:0];
                                    o_cmd.col  = r_col;
                                    o_cmd.row  = r_row;
                                    n_unit     = unit_inc;
                                    if (unit_inc == vqd_pkg::V4_BYTES) begin
                                        n_col = nb_col;
                                        n_row = nb_row;
                                        n_adv = ADV_VQ_BLK;
                                    end
                                end
                                default: begin
                                end
                            endcase
                            // The chunk is used up: nothing later can matter.
                            if (bytes_dec == 24'd0) begin
                                n_phase = PH_IDLE;
                                n_adv   = ADV_NONE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (do_skip) begin
            n_phase = (r_bytes != 24'd0) ? PH_SKIP : PH_IDLE;
        end
        if (do_need) begin
            if (r_bytes < {21'b0, need_n}) begin
                n_phase = (r_bytes != 24'd0) ? PH_SKIP : PH_IDLE;
            end else begin
                n_phase  = need_ph;
                n_unit   = '0;
                n_ebytes = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= vqd_pkg::WIDTH_RESET;
            r_strip_top <= '0;
            r_strip_bot <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_flags     <= '0;
            r_mask      <= '0;
            r_bytes     <= '0;
            r_chunk     <= '0;
            r_entry     <= '0;
            r_ebytes    <= '0;
            r_unit      <= '0;
            r_phase     <= PH_IDLE;
            r_adv       <= ADV_NONE;
            r_halted    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_cfg_data;
            end
            r_strip_top <= n_strip_top;
            r_strip_bot <= n_strip_bot;
            r_col       <= n_col;
            r_row       <= n_row;
            r_flags     <= n_flags;
            r_mask      <= n_mask;
            r_bytes     <= n_bytes;
            r_chunk     <= n_chunk;
            r_entry     <= n_entry;
            r_ebytes    <= n_ebytes;
            r_unit      <= n_unit;
            r_phase     <= n_phase;
            r_adv       <= n_adv;
            r_halted    <= n_halted;
        end
    end

    // A halted decoder has no chunk open.
    `VQD_ASSERT_IMP(a_halt_idle, i_clk, i_rst_n, r_halted, r_phase == PH_IDLE)

endmodule

### hdl/vqd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// vqd_cmd_fifo
// Four-deep command queue between the parser and the pixel engine.
// ----------------------------------------------------------------------------
`include "vq_codebook_video_block_decoder_unit_assert.svh"

module vqd_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vqd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output vqd_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    vqd_pkg::t_cmd r_mem [4];
    logic [1:0]    r_wp;
    logic [1:0]    r_rp;
    logic [2:0]    r_count;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_count <= r_count + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

    `VQD_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, o_full, !i_push)
    `VQD_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, o_empty, !i_pop)

endmodule

### hdl/vqd_back.sv
// ----------------------------------------------------------------------------
// vqd_back
// Pixel engine: holds both codebooks, writes entries, and expands V1 and V4
// commands into converted RGB pixels, one slot per cycle if not stalled.
// ----------------------------------------------------------------------------
`include "vq_codebook_video_block_decoder_unit_assert.svh"

module vqd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vqd_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    output vqd_pkg::t_out o_data,
    input  logic          i_stall
);

    // Returns {later pixel exists, smallest row offset among later pixels}.
    function automatic logic [2:0] later_min(input vqd_pkg::t_op op,
                                              input logic [3:0] pos,
                                              input logic [1:0] quad);
        logic [2:0] res;
        res = 3'b000;
        if (op == vqd_pkg::OP_V1) begin
            if (pos <= 4'd4) begin
                res = 3'b100;
            end else if (pos <= 4'd6) begin
                res = 3'b101;
            end else if (pos <= 4'd12) begin
                res = 3'b110;
            end else if (pos <= 4'd14) begin
                res = 3'b111;
            end
        end else if (op == vqd_pkg::OP_V4) begin
            if (pos == 4'd0) begin
                res = {1'b1, quad[1], 1'b0};
            end else if (pos <= 4'd2) begin
                res = {1'b1, quad[1], 1'b1};
            end
        end
        return res;
    endfunction

    logic [47:0]   r_mem [512];
    logic [47:0]   r_rd;
    vqd_pkg::t_cmd r_cmd;
    logic          r_busy;
    logic [3:0]    r_pos;
    logic          r_out_v;
    vqd_pkg::t_out r_out;

    logic          advance;
    logic [3:0]    final_pos;
    logic          at_final;
    logic [1:0]    q;
    logic [1:0]    p;
    logic [12:0]   pix_y;
    logic          pix_ok;
    logic [2:0]    lm;
    logic [12:0]   later_y;
    logic          is_last;
    logic [7:0]    luma;
    logic signed [8:0]  uu;
    logic signed [8:0]  vv;
    logic signed [8:0]  uu_half;
    logic signed [10:0] ys;
    logic signed [10:0] us;
    logic signed [10:0] vs;
    logic signed [10:0] uhs;
    logic signed [10:0] red_s;
    logic signed [10:0] green_s;
    logic signed [10:0] blue_s;

    assign advance   = !r_out_v || !i_stall;
    assign final_pos = (r_cmd.op == vqd_pkg::OP_V1) ? 4'd15
                     : (r_cmd.op == vqd_pkg::OP_V4) ? 4'd3 : 4'd0;
    assign at_final  = (r_pos == final_pos);
    assign o_pop     = !i_empty && (!r_busy || (advance && at_final));
    assign q         = (r_cmd.op == vqd_pkg::OP_V1) ? r_pos[3:2] : r_cmd.quad;
    assign p         = r_pos[1:0];
    assign pix_y     = r_cmd.row + {11'b0, q[1], p[1]};
    assign pix_ok    = !pix_y[12];
    assign lm        = later_min(r_cmd.op, r_pos, r_cmd.quad);
    assign later_y   = r_cmd.row + {11'b0, lm[1:0]};
    assign is_last   = !lm[2] || later_y[12];

    always_comb begin
        case ((r_cmd.op == vqd_pkg::OP_V1) ? q : p)
            2'd0:    luma = r_rd[47:40];
            2'd1:    luma = r_rd[39:32];
            2'd2:    luma = r_rd[31:24];
            default: luma = r_rd[23:16];
        endcase
    end

    // YUV to RGB; the halving of u truncates toward zero.
    assign uu      = $signed({1'b0, r_rd[15:8]}) - 9'sd128;
    assign vv      = $signed({1'b0, r_rd[7:0]}) - 9'sd128;
    assign uu_half = (uu + $signed({8'b0, uu[8]})) >>> 1;
    assign ys      = $signed({3'b000, luma});
    assign us      = 11'(uu);
    assign vs      = 11'(vv);
    assign uhs     = 11'(uu_half);
    assign red_s   = ys + (vs <<< 1);
    assign green_s = ys - uhs - vs;
    assign blue_s  = ys + (us <<< 1);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_cmd.op == vqd_pkg::OP_WRITE) begin
                r_mem[{i_cmd.tsel, i_cmd.idx}] <= i_cmd.data;
            end
            r_rd <= r_mem[{i_cmd.op == vqd_pkg::OP_V1, i_cmd.idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_busy && advance) begin
            r_out.status  <= (r_cmd.op == vqd_pkg::OP_ERR);
            r_out.pixel_x <= (r_cmd.op == vqd_pkg::OP_ERR) ? 12'd0
                                                           : {r_cmd.col, q[0], p[0]};
            r_out.pixel_y <= (r_cmd.op == vqd_pkg::OP_ERR) ? 12'd0 : pix_y[11:0];
            r_out.red     <= (r_cmd.op == vqd_pkg::OP_ERR) ? 8'd0 : vqd_pkg::clip8(red_s);
            r_out.green   <= (r_cmd.op == vqd_pkg::OP_ERR) ? 8'd0
                                                           : vqd_pkg::clip8(green_s);
            r_out.blue    <= (r_cmd.op == vqd_pkg::OP_ERR) ? 8'd0 : vqd_pkg::clip8(blue_s);
            r_out.last    <= (r_cmd.op == vqd_pkg::OP_ERR) || is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pos   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (advance) begin
                r_out_v <= r_busy && ((r_cmd.op == vqd_pkg::OP_ERR) || pix_ok);
            end
            if (o_pop) begin
                r_busy <= (i_cmd.op != vqd_pkg::OP_WRITE);
                r_pos  <= '0;
            end else if (r_busy && advance) begin
                if (at_final) begin
                    r_busy <= 1'b0;
                end
                r_pos <= r_pos + 4'd1;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // An error word is always the only word of its item.
    `VQD_ASSERT_IMP(a_err_last, i_clk, i_rst_n, r_out_v && r_out.status, r_out.last)

endmodule

### hdl/vq_codebook_video_block_decoder_unit.sv
// Path: command queue, then pixel engine command and entry registers, and output register.
// Throughput: a V1 byte expands to 16 pixel slots and a V4 byte to 4, one slot per cycle
// in the pixel engine while the output is not stalled; the parser stalls the input
// while it steps over skipped blocks or unselected codebook entries.
// Reset: synchronous, active low; clears the parser, queue and output; codebooks keep data.
// ----------------------------------------------------------------------------
// vq_codebook_video_block_decoder_unit
// Vector-quantization video block decoder: a stream parser feeds a short
// command queue that a pixel engine with both codebooks drains.
// ----------------------------------------------------------------------------
`include "vq_codebook_video_block_decoder_unit_assert.svh"

module vq_codebook_video_block_decoder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input words.
    input  logic          i_in_valid,
    input  vqd_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    // Result words.
    output logic          o_out_valid,
    output vqd_pkg::t_out o_out_data,
    input  logic          i_out_stall,
    // Frame width register in 4-pixel blocks.
    input  logic          i_cfg_valid,
    input  logic [10:0]   i_cfg_data,
    output logic          o_cfg_ready
);

    // The parser stalls the input while it steps through flag bits or blocks,
    // and while the command queue is full. The pixel engine drains the queue
    // independently, so a stall on one side holds up the other only once the queue fills.

    logic          push;
    logic          full;
    logic          pop;
    logic          empty;
    vqd_pkg::t_cmd cmd_in;
    vqd_pkg::t_cmd cmd_out;

    // The user must write the width register only while the decoder is idle; the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    vqd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_data      (i_in_data),
        .o_stall     (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .i_full      (full)
    );

    vqd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty)
    );

    vqd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_out),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule
